[rtl/esa_pkg.sv]
// ----------------------------------------------------------------------------
// esa_pkg
// Shared sizes, codes and types of the exact-size block allocator.
// ----------------------------------------------------------------------------
package esa_pkg;

	localparam int MAX_BLOCKS   = 64;
	localparam int HEADER_BYTES = 24;

	localparam int ADDR_W    = 32;
	localparam int SIZE_W    = 32;
	localparam int IDX_BITS  = $clog2(MAX_BLOCKS);
	localparam int CNT_BITS  = $clog2(MAX_BLOCKS + 1);
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_HEAP_LIMIT = CFG_IDX_W'(1);

	localparam logic [ADDR_W-1:0] HEAP_BASE_RESET  = ADDR_W'(65536);
	localparam logic [ADDR_W-1:0] HEAP_LIMIT_RESET = ADDR_W'(1048576);

	localparam logic MODE_ALLOC = 1'b0;
	localparam logic MODE_FREE  = 1'b1;

	typedef enum logic [2:0] {
		ST_REUSED   = 3'd0,
		ST_NEW      = 3'd1,
		ST_FREED    = 3'd2,
		ST_ZERO     = 3'd3,
		ST_NOSPACE  = 3'd4,
		ST_NULLFREE = 3'd5,
		ST_UNKNOWN  = 3'd6
	} status_t;

	typedef struct packed {
		logic [SIZE_W-1:0] size;
		logic [ADDR_W-1:0] address;
		logic              free;
	} entry_t;

endpackage

[rtl/esa_req_if.sv]
// ----------------------------------------------------------------------------
// esa_req_if
// Request channel of the allocator: allocate or free, with its operands.
// ----------------------------------------------------------------------------
interface esa_req_if;
	logic                      valid;
	logic                      ready;
	logic                      mode;
	logic [esa_pkg::SIZE_W-1:0] request_size;
	logic [esa_pkg::ADDR_W-1:0] block_address;

	modport source (output valid, output mode, output request_size,
		output block_address, input ready);
	modport sink (input valid, input mode, input request_size,
		input block_address, output ready);
endinterface

[rtl/esa_rsp_if.sv]
// ----------------------------------------------------------------------------
// esa_rsp_if
// Result channel of the allocator: payload address and status code.
// ----------------------------------------------------------------------------
interface esa_rsp_if;
	logic                       valid;
	logic                       ready;
	logic [esa_pkg::ADDR_W-1:0] payload_address;
	logic [2:0]                 status;

	modport source (output valid, output payload_address, output status, input ready);
	modport sink (input valid, input payload_address, input status, output ready);
endinterface

[rtl/exact_size_block_allocator_top.sv]
// ----------------------------------------------------------------------------
// exact_size_block_allocator_top
// Heap block allocator with a table of exact-size blocks in creation order.
// ----------------------------------------------------------------------------
// The allocator takes one request at a time and gives exactly one result per
// request. Allocate and free requests walk the block table, which sits in a
// memory with one read port, one write port and a registered read, one entry
// per cycle. An allocate that finds no free entry of its size goes on through
// an append and a commit step to add a new block; a zero-size allocate or a
// null free skips the scan and goes straight to the result. The scan time is
// set by the table memory's single read port. Results wait in an output
// register, so a new request is taken as soon as the previous one has been
// handed over to it. The user must write heap_base and heap_limit through the
// plain configuration port only while the block is idle; the block itself
// does not enforce this. A heap_base write also moves the break pointer while
// the table is empty.
// ----------------------------------------------------------------------------
module exact_size_block_allocator_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [esa_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [esa_pkg::CFG_DATA_W-1:0]     cfg_data,
	esa_req_if.sink                            req,
	esa_rsp_if.source                          rsp
);

	localparam int END_W = esa_pkg::ADDR_W + 2;

	// One-hot sequencer states.
	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_SCAN   = 5'b00010,
		S_APPEND = 5'b00100,
		S_COMMIT = 5'b01000,
		S_RESP   = 5'b10000
	} state_t;

	state_t state_q;

	// Configuration and heap state.
	logic [esa_pkg::ADDR_W-1:0]   heap_limit_q;
	logic [esa_pkg::ADDR_W-1:0]   break_q;
	logic [esa_pkg::CNT_BITS-1:0] count_q;

	// The latched request.
	logic                         mode_q;
	logic [esa_pkg::SIZE_W-1:0]   size_q;
	logic [esa_pkg::ADDR_W-1:0]   where_q;

	// Scan pointer and the compare stage, which checks an entry in the cycle after its memory read.
	logic [esa_pkg::CNT_BITS-1:0] rd_q;
	logic                         chk_valid_s1;
	logic [esa_pkg::IDX_BITS-1:0] chk_idx_s1;

	// Append computation, registered between the add and the limit compare.
	logic [END_W-1:0]             end_q;
	logic [esa_pkg::ADDR_W-1:0]   new_addr_q;
	logic                         full_q;

	// Result waiting for the output register, and the output register itself.
	logic [esa_pkg::ADDR_W-1:0]   res_addr_q;
	esa_pkg::status_t             res_status_q;
	logic                         out_valid_q;
	logic [esa_pkg::ADDR_W-1:0]   out_addr_q;
	esa_pkg::status_t             out_status_q;

	// Block table.
	esa_pkg::entry_t              mem [esa_pkg::MAX_BLOCKS];
	esa_pkg::entry_t              mem_rdata;
	esa_pkg::entry_t              mem_wdata;
	logic                         mem_we;
	logic                         mem_re;
	logic [esa_pkg::IDX_BITS-1:0] mem_waddr;
	logic [esa_pkg::IDX_BITS-1:0] mem_raddr;

	logic accept;
	logic hit;
	logic more;
	logic out_load;
	logic no_space;

	assign accept   = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);

	// A free matches on payload address; an allocate needs a free entry of the exact size.
	assign hit = chk_valid_s1 && ((mode_q == esa_pkg::MODE_FREE)
		? (mem_rdata.address == where_q)
		: (mem_rdata.free && (mem_rdata.size == size_q)));

	assign more = (rd_q < count_q);

	assign mem_re    = (state_q == S_SCAN) && more;
	assign mem_raddr = rd_q[esa_pkg::IDX_BITS-1:0];

	assign no_space = full_q || (end_q > {2'b00, heap_limit_q});

	// The table is written in two places: a hit rewrites the free mark of the
	// matched entry, and a successful append fills the entry at the count.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = chk_idx_s1;
		mem_wdata = mem_rdata;
		if ((state_q == S_SCAN) && hit) begin
			mem_we         = 1'b1;
			mem_wdata.free = (mode_q == esa_pkg::MODE_FREE);
		end else if ((state_q == S_COMMIT) && !no_space) begin
			mem_we            = 1'b1;
			mem_waddr         = count_q[esa_pkg::IDX_BITS-1:0];
			mem_wdata.size    = size_q;
			mem_wdata.address = new_addr_q;
			mem_wdata.free    = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			mem_rdata <= mem[mem_raddr];
		end
	end

	assign out_load = (state_q == S_RESP) && (!out_valid_q || rsp.ready);

	// Sequencer and heap bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			heap_limit_q <= esa_pkg::HEAP_LIMIT_RESET;
			break_q      <= esa_pkg::HEAP_BASE_RESET;
			count_q      <= '0;
			rd_q         <= '0;
			chk_valid_s1 <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					esa_pkg::CFG_HEAP_BASE: begin
						if (count_q == '0) begin
							break_q <= cfg_data;
						end
					end
					esa_pkg::CFG_HEAP_LIMIT: begin
						heap_limit_q <= cfg_data;
					end
					default: begin
					end
				endcase
			end

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						rd_q         <= '0;
						chk_valid_s1 <= 1'b0;
						if ((req.mode == esa_pkg::MODE_ALLOC) && (req.request_size == '0)) begin
							state_q <= S_RESP;
						end else if ((req.mode == esa_pkg::MODE_FREE)
								&& (req.block_address == '0)) begin
							state_q <= S_RESP;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (hit) begin
						chk_valid_s1 <= 1'b0;
						state_q      <= S_RESP;
					end else if (more) begin
						rd_q         <= rd_q + 1'b1;
						chk_valid_s1 <= 1'b1;
					end else if (chk_valid_s1) begin
						chk_valid_s1 <= 1'b0;
					end else if (mode_q == esa_pkg::MODE_FREE) begin
						state_q <= S_RESP;
					end else begin
						state_q <= S_APPEND;
					end
				end
				S_APPEND: begin
					state_q <= S_COMMIT;
				end
				S_COMMIT: begin
					if (!no_space) begin
						count_q <= count_q + 1'b1;
						break_q <= end_q[esa_pkg::ADDR_W-1:0];
					end
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Request, scan and result payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q     <= req.mode;
			size_q     <= req.request_size;
			where_q    <= req.block_address;
			res_addr_q <= '0;
			if (req.mode == esa_pkg::MODE_ALLOC) begin
				res_status_q <= esa_pkg::ST_ZERO;
			end else begin
				res_status_q <= esa_pkg::ST_NULLFREE;
			end
		end
		if (mem_re) begin
			chk_idx_s1 <= mem_raddr;
		end
		if ((state_q == S_SCAN) && hit) begin
			if (mode_q == esa_pkg::MODE_FREE) begin
				res_addr_q   <= '0;
				res_status_q <= esa_pkg::ST_FREED;
			end else begin
				res_addr_q   <= mem_rdata.address;
				res_status_q <= esa_pkg::ST_REUSED;
			end
		end else if ((state_q == S_SCAN) && !more && !chk_valid_s1) begin
			res_addr_q   <= '0;
			res_status_q <= esa_pkg::ST_UNKNOWN;
		end
		if (state_q == S_APPEND) begin
			// Without wrap: break + header + size needs two bits above the address.
			end_q      <= {2'b00, break_q} + END_W'(esa_pkg::HEADER_BYTES) + {2'b00, size_q};
			new_addr_q <= break_q + esa_pkg::ADDR_W'(esa_pkg::HEADER_BYTES);
			full_q     <= (count_q >= esa_pkg::CNT_BITS'(esa_pkg::MAX_BLOCKS));
		end
		if (state_q == S_COMMIT) begin
			if (no_space) begin
				res_addr_q   <= '0;
				res_status_q <= esa_pkg::ST_NOSPACE;
			end else begin
				res_addr_q   <= new_addr_q;
				res_status_q <= esa_pkg::ST_NEW;
			end
		end
		if (out_load) begin
			out_addr_q   <= res_addr_q;
			out_status_q <= res_status_q;
		end
	end

	// Output register: holds a result until the consumer takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign rsp.valid           = out_valid_q;
	assign rsp.payload_address = out_addr_q;
	assign rsp.status          = out_status_q;

`ifndef SYNTHESIS
	// The table never holds more entries than it has rows.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= esa_pkg::CNT_BITS'(esa_pkg::MAX_BLOCKS))
		else $error("entry count beyond table depth");

	// The entry count only grows through a successful append.
	a_count_commit: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |-> ($past(state_q) == S_COMMIT))
		else $error("entry count changed outside an append");

	// The table is written only on a scan hit or an append.
	a_write_state: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> ((state_q == S_SCAN) || (state_q == S_COMMIT)))
		else $error("table written outside scan or append");

	// A free never hands out an address.
	a_free_null: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_status_q == esa_pkg::ST_FREED)) |-> (out_addr_q == '0))
		else $error("free result carries an address");
`endif

endmodule
